// ===== rtl/rcpwcf_pkg.sv =====
package rcpwcf_pkg;

    // Channel count and field widths
    localparam int NUM_CH    = 6;
    localparam int CH_W      = 3;
    localparam int CAP_W     = 16;
    localparam int VAL_W     = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SMOOTH_W  = 9;

    // Clamp limits of the smoothed value
    localparam logic [VAL_W-1:0] VAL_MIN = 12'd500;
    localparam logic [VAL_W-1:0] VAL_MAX = 12'd2500;

    // Unity weight in Q1.8
    localparam logic [SMOOTH_W-1:0] Q_ONE = 9'd256;

    // Highest channel that uses the group A period
    localparam logic [CH_W-1:0] GROUP_A_LAST = 3'd3;

    // Reset values of the configuration registers
    localparam logic [CAP_W-1:0]    PERIOD_RESET    = 16'hFFFF;
    localparam logic [SMOOTH_W-1:0] SMOOTHING_RESET = 9'd128;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_A  = 2'd0,
        CFG_PERIOD_B  = 2'd1,
        CFG_SMOOTHING = 2'd2
    } cfg_idx_t;

    // One capture event
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [CAP_W-1:0] capture_value;
        logic             pin_high;
    } cap_item_t;

    // Pulse widths and smoothed values of all channels
    typedef logic [NUM_CH-1:0][CAP_W-1:0] width_vec_t;
    typedef logic [NUM_CH-1:0][VAL_W-1:0] value_vec_t;

endpackage

// ===== rtl/rcpwcf_capture.sv =====
module rcpwcf_capture #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  rcpwcf_pkg::cap_item_t           item,
    input  logic [rcpwcf_pkg::CAP_W-1:0]    period_a,
    input  logic [rcpwcf_pkg::CAP_W-1:0]    period_b,
    output logic                            done,
    output rcpwcf_pkg::width_vec_t          pulse_width
);
    import rcpwcf_pkg::*;

    localparam int MB = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
    localparam logic [CAP_W-1:0] WMASK = CAP_W'((17'd1 << MB) - 17'd1);
    localparam bit WIDE = (COUNTER_BITS > CAP_W);

    logic [CAP_W-1:0] rise_count_reg [NUM_CH];
    logic [NUM_CH-1:0] await_rise_reg;
    width_vec_t       pulse_width_reg;

    logic [CAP_W-1:0] rise_sel;
    logic             await_sel;
    logic             ch_ok;
    logic [CAP_W-1:0] period_m;
    logic [CAP_W-1:0] fall_m;
    logic [CAP_W-1:0] rise_m;
    logic [CAP_W+1:0] wrap_sum;
    logic [CAP_W-1:0] width_new;

    // Select the state of the addressed channel
    always_comb
    begin
        rise_sel  = '0;
        await_sel = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (item.channel == CH_W'(i))
            begin
                rise_sel  = rise_count_reg[i];
                await_sel = await_rise_reg[i];
            end
        end
    end

    assign ch_ok = (item.channel < CH_W'(NUM_CH));

    // Pulse width, wrapping at the timer period
    always_comb
    begin
        period_m = ((item.channel <= GROUP_A_LAST) ? period_a : period_b) & WMASK;
        fall_m   = item.capture_value & WMASK;
        rise_m   = rise_sel & WMASK;
        wrap_sum = (CAP_W+2)'(period_m) - (CAP_W+2)'(rise_m) + (CAP_W+2)'(fall_m)
                   + (CAP_W+2)'(1);
        if (fall_m >= rise_m)
            width_new = fall_m - rise_m;
        else if (WIDE)
            width_new = wrap_sum[CAP_W+1] ? '1 : wrap_sum[CAP_W-1:0];
        else
            width_new = wrap_sum[CAP_W-1:0] & WMASK;
    end

    assign done = ch_ok && !await_sel;

    // Update the addressed channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
                rise_count_reg[i] <= '0;
            await_rise_reg  <= '1;
            pulse_width_reg <= '0;
        end
        else if (advance && ch_ok)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (item.channel == CH_W'(i))
                begin
                    if (await_rise_reg[i])
                    begin
                        rise_count_reg[i] <= item.capture_value & WMASK;
                        if (item.pin_high)
                            await_rise_reg[i] <= 1'b0;
                    end
                    else
                    begin
                        pulse_width_reg[i] <= width_new;
                        await_rise_reg[i]  <= 1'b1;
                    end
                end
            end
        end
    end

    assign pulse_width = pulse_width_reg;

endmodule

// ===== rtl/rcpwcf_smooth_lane.sv =====
module rcpwcf_smooth_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               update,
    input  logic [rcpwcf_pkg::SMOOTH_W-1:0]    weight,
    input  logic [rcpwcf_pkg::CAP_W-1:0]       width,
    output logic [rcpwcf_pkg::VAL_W-1:0]       value
);
    import rcpwcf_pkg::*;

    localparam int ACC_W = 26;

    logic [VAL_W-1:0]    value_reg;
    logic [VAL_W-1:0]    value_next;
    logic [SMOOTH_W-1:0] inv_weight;
    logic [ACC_W-1:0]    acc;
    logic [ACC_W-9:0]    scaled;

    // Blend old value and new width, then clamp
    always_comb
    begin
        inv_weight = Q_ONE - weight;
        acc        = ACC_W'(value_reg) * ACC_W'(weight) + ACC_W'(width) * ACC_W'(inv_weight);
        scaled     = acc[ACC_W-1:8];
        if (scaled < (ACC_W-8)'(VAL_MIN))
            value_next = VAL_MIN;
        else if (scaled > (ACC_W-8)'(VAL_MAX))
            value_next = VAL_MAX;
        else
            value_next = scaled[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else if (update)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/rc_pulse_width_capture_filter_core.sv =====
// Channel | Dir | Payload
// s_*     | in  | tdata: capture_value, pin_high; tuser: channel
// m_*     | out | tdata: value_0..value_5; tuser: pulse_done
// cfg_*   | in  | write enable, register index, data
//
// One transaction per cycle sustained while m_tready is high; a result passes the input
// register, the capture update and the smoothing/output register in turn.
// The capture state update and the six smoothing multipliers are each registered.
// rst_n is asynchronous; it clears all channel state and restores the register defaults.
// A stalled m_tready holds the result and back-pressures s_tready through the stages.
module rc_pulse_width_capture_filter_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [23:0]                          s_tdata,   // capture_value, pin_high
    input  logic [2:0]                           s_tuser,   // channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [71:0]                          m_tdata,   // value_0 .. value_5
    output logic [0:0]                           m_tuser,   // pulse_done
    input  logic                                 cfg_we,
    input  logic [rcpwcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcpwcf_pkg::CFG_W-1:0]         cfg_data
);
    import rcpwcf_pkg::*;

    logic [CAP_W-1:0]    period_a_reg;
    logic [CAP_W-1:0]    period_b_reg;
    logic [SMOOTH_W-1:0] smoothing_reg;

    cap_item_t item_reg;
    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      s2_done_reg;
    logic      out_valid_reg;
    logic      out_done_reg;

    logic       out_free;
    logic       s2_adv;
    logic       s2_free;
    logic       s1_adv;
    logic       cap_done;
    width_vec_t pulse_width;
    value_vec_t smoothed;
    logic [SMOOTH_W-1:0] weight;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_a_reg  <= PERIOD_RESET;
            period_b_reg  <= PERIOD_RESET;
            smoothing_reg <= SMOOTHING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PERIOD_A:  period_a_reg  <= cfg_data;
                CFG_PERIOD_B:  period_b_reg  <= cfg_data;
                CFG_SMOOTHING: smoothing_reg <= cfg_data[SMOOTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage flow control
    assign out_free = !out_valid_reg || m_tready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s1_adv;

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.channel       <= s_tuser;
            item_reg.capture_value <= s_tdata[15:0];
            item_reg.pin_high      <= s_tdata[16];
        end
    end

    // Valid and done flags along the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_done_reg  <= cap_done;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
                out_done_reg  <= s2_done_reg;
            end
        end
    end

    rcpwcf_capture #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (s1_adv),
        .item        (item_reg),
        .period_a    (period_a_reg),
        .period_b    (period_b_reg),
        .done        (cap_done),
        .pulse_width (pulse_width)
    );

    // Saturate the weight at unity
    assign weight = (smoothing_reg > Q_ONE) ? Q_ONE : smoothing_reg;

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        rcpwcf_smooth_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .update (s2_adv),
            .weight (weight),
            .width  (pulse_width[g]),
            .value  (smoothed[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = smoothed;
    assign m_tuser  = out_done_reg;

`ifndef SYNTHESIS
    // A held stage two must block stage one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |-> !s1_adv)
        else $error("stage one advanced into a held stage two");

    // Offered results of channels 0 and 5 lie within the clamp range
    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (smoothed[0] >= VAL_MIN && smoothed[0] <= VAL_MAX &&
                      smoothed[5] >= VAL_MIN && smoothed[5] <= VAL_MAX))
        else $error("smoothed value outside clamp range");

    // An out of range channel leaves all pulse widths alone
    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && item_reg.channel >= CH_W'(NUM_CH)) |=> $stable(pulse_width))
        else $error("invalid channel changed a pulse width");

    // A completed pulse reaches stage two with its done flag
    a_done_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && cap_done) |=> (s2_valid_reg && s2_done_reg))
        else $error("done flag lost between stages");
`endif

endmodule
